>>> hw/rtl/ppid_pkg.sv
`timescale 1ns / 1ps

package ppid_pkg;

	// Trajectory store geometry.
	localparam int TRAJ_DEPTH = 1024;
	localparam int TRAJ_AW    = $clog2(TRAJ_DEPTH);
	localparam int LEN_W      = 11;
	localparam int CNT_W      = (TRAJ_AW + 1 > LEN_W) ? TRAJ_AW + 1 : LEN_W;

	// Configuration port.
	localparam int PADDR_W = 5;

	// Datapath widths: 24 x 33 signed products, Q.8 accumulator.
	localparam int GAIN_W = 24;
	localparam int PROD_W = 57;
	localparam int MAG_W  = 57;
	localparam int ACC_W  = 59;

	// Proportional term limit in whole units.
	localparam int P_LIMIT = 2000;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_HOLD  = 2'd1,
		MODE_TRACK = 2'd2,
		MODE_OFF   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_P_GAIN      = 3'd0,
		REG_I_GAIN      = 3'd1,
		REG_D_GAIN      = 3'd2,
		REG_HOLD_TARGET = 3'd3,
		REG_TRAJ_LENGTH = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [1:0]         mode;
		logic signed [31:0] encoder_count;
		logic [9:0]         table_index;
		logic signed [31:0] table_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] current_command;
		logic               command_positive;
		logic               track_done;
		logic signed [31:0] read_value;
	} result_t;

endpackage

>>> hw/rtl/position_pid_trajectory_controller.sv
// Channel      Direction  Handshake                     Payload
// item         in         item_valid / item_ready       ppid_pkg::item_t
// result       out        result_valid / result_ready   ppid_pkg::result_t
// config (APB) in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A control tick in hold mode passes from the accepted beat through error, integral, three
// multiplies, accumulation, proportional halving and rounding to the result register;
// a track tick first reads its reference entry. Writes, idle ticks and unused operations
// go straight to the output step, and a read of the measured store passes a read state first.
// The single shared 24 x 33 multiplier is used three times per tick, and the shifter
// halves the proportional term one bit per cycle.
// Reset (arst_n low) restores the gain defaults and clears the integral, last error and
// track position; the two trajectory stores are not cleared and need no clearing pass.
// A finished result waits in the output register while the next beat is accepted; the
// sequencer only stalls at its final step if that register is still occupied.
`timescale 1ns / 1ps

module position_pid_trajectory_controller (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           item_valid,
	output logic                           item_ready,
	input  ppid_pkg::item_t                item,

	output logic                           result_valid,
	input  logic                           result_ready,
	output ppid_pkg::result_t              result,

	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ppid_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	// The sequencer walks one tick through error, integral, three shared multiplies,
	// accumulation, proportional halving and final rounding.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TARGET,
		ST_READ,
		ST_ERR,
		ST_INTEG,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_D,
		ST_ACC_D,
		ST_HALVE,
		ST_FIN,
		ST_PUSH
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic signed [ppid_pkg::GAIN_W-1:0] p_gain_q;
	logic signed [ppid_pkg::GAIN_W-1:0] i_gain_q;
	logic signed [ppid_pkg::GAIN_W-1:0] d_gain_q;
	logic signed [31:0]                 hold_target_q;
	logic [ppid_pkg::LEN_W-1:0]         traj_len_q;

	// Controller state.
	logic signed [31:0]                 esum_q;
	logic signed [31:0]                 last_err_q;
	logic [ppid_pkg::TRAJ_AW-1:0]       track_pos_q;

	// Datapath registers.
	logic                               track_q;
	logic signed [31:0]                 enc_q;
	logic signed [31:0]                 target_q;
	logic signed [31:0]                 err_q;
	logic signed [32:0]                 dterm_q;
	logic signed [ppid_pkg::PROD_W-1:0] prod_q;
	logic [ppid_pkg::MAG_W-1:0]         mag_q;
	logic                               psign_q;
	logic signed [ppid_pkg::ACC_W-1:0]  acc_q;
	ppid_pkg::result_t                  res_q;

	// Output register.
	logic                               result_valid_q;
	ppid_pkg::result_t                  result_q;

	// Store ports.
	logic                               ref_we;
	logic                               ref_re;
	logic [ppid_pkg::TRAJ_AW-1:0]       ref_waddr;
	logic [31:0]                        ref_rdata;
	logic                               meas_we;
	logic                               meas_re;
	logic [ppid_pkg::TRAJ_AW-1:0]       meas_raddr;
	logic [31:0]                        meas_rdata;

	logic                               accept;
	logic                               push;
	logic                               cfg_write;
	logic                               is_tick;
	logic                               is_hold;
	logic                               is_track;

	logic signed [ppid_pkg::GAIN_W-1:0] mul_a;
	logic signed [32:0]                 mul_b;
	logic signed [ppid_pkg::PROD_W-1:0] prod_d;

	logic [ppid_pkg::CNT_W-1:0]         len_eff;
	logic [ppid_pkg::CNT_W-1:0]         trk_next;
	logic                               trk_wrap;

	logic                               halve_more;
	logic signed [ppid_pkg::ACC_W-1:0]  acc_adj;
	logic signed [ppid_pkg::ACC_W-1:0]  acc_whole;
	logic signed [31:0]                 cmd_sat;

	// Saturates a 33-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] == v[31]) begin
			r = v[31:0];
		end else if (v[32]) begin
			r = 32'sh8000_0000;
		end else begin
			r = 32'sh7FFF_FFFF;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------------------
	// Configuration port. Writes land in the access phase; pready never stalls.
	// ---------------------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_gain_q      <= 24'sd17920;
			i_gain_q      <= '0;
			d_gain_q      <= 24'sd15360;
			hold_target_q <= '0;
			traj_len_q    <= '0;
		end else if (cfg_write) begin
			unique case (paddr[4:2])
				ppid_pkg::REG_P_GAIN:      p_gain_q      <= pwdata[ppid_pkg::GAIN_W-1:0];
				ppid_pkg::REG_I_GAIN:      i_gain_q      <= pwdata[ppid_pkg::GAIN_W-1:0];
				ppid_pkg::REG_D_GAIN:      d_gain_q      <= pwdata[ppid_pkg::GAIN_W-1:0];
				ppid_pkg::REG_HOLD_TARGET: hold_target_q <= pwdata;
				ppid_pkg::REG_TRAJ_LENGTH: traj_len_q    <= pwdata[ppid_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Reads return the gains sign-extended and the length zero-extended.
	always_comb begin
		unique case (paddr[4:2])
			ppid_pkg::REG_P_GAIN:      prdata = 32'(p_gain_q);
			ppid_pkg::REG_I_GAIN:      prdata = 32'(i_gain_q);
			ppid_pkg::REG_D_GAIN:      prdata = 32'(d_gain_q);
			ppid_pkg::REG_HOLD_TARGET: prdata = hold_target_q;
			ppid_pkg::REG_TRAJ_LENGTH: prdata = 32'(traj_len_q);
			default:                   prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------------------
	// Input decode and trajectory stores.
	// ---------------------------------------------------------------------------------
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign is_tick    = (item.operation == ppid_pkg::OP_TICK);
	assign is_hold    = is_tick && (item.mode == ppid_pkg::MODE_HOLD);
	assign is_track   = is_tick && (item.mode == ppid_pkg::MODE_TRACK);

	// The reference entry for a track tick is read at the current position, and the
	// encoder count is recorded at that same position, both at the accepting edge.
	assign ref_we     = accept && (item.operation == ppid_pkg::OP_WRITE);
	assign ref_waddr  = ppid_pkg::TRAJ_AW'(item.table_index);
	assign ref_re     = accept && is_track;
	assign meas_we    = accept && is_track;
	assign meas_re    = accept && (item.operation == ppid_pkg::OP_READ);
	assign meas_raddr = ppid_pkg::TRAJ_AW'(item.table_index);

	ppid_ram #(
		.WIDTH (32),
		.DEPTH (ppid_pkg::TRAJ_DEPTH)
	) u_ref_store (
		.clk   (clk),
		.we    (ref_we),
		.waddr (ref_waddr),
		.wdata (item.table_value),
		.re    (ref_re),
		.raddr (track_pos_q),
		.rdata (ref_rdata)
	);

	ppid_ram #(
		.WIDTH (32),
		.DEPTH (ppid_pkg::TRAJ_DEPTH)
	) u_meas_store (
		.clk   (clk),
		.we    (meas_we),
		.waddr (track_pos_q),
		.wdata (item.encoder_count),
		.re    (meas_re),
		.raddr (meas_raddr),
		.rdata (meas_rdata)
	);

	// ---------------------------------------------------------------------------------
	// Track stepping. A length above the store depth is clamped to the depth, and a
	// length of zero ends the trajectory on every tick.
	// ---------------------------------------------------------------------------------
	assign len_eff  = (ppid_pkg::CNT_W'(traj_len_q) > ppid_pkg::CNT_W'(ppid_pkg::TRAJ_DEPTH))
		? ppid_pkg::CNT_W'(ppid_pkg::TRAJ_DEPTH) : ppid_pkg::CNT_W'(traj_len_q);
	assign trk_next = ppid_pkg::CNT_W'(track_pos_q) + ppid_pkg::CNT_W'(1);
	assign trk_wrap = (trk_next >= len_eff);

	// ---------------------------------------------------------------------------------
	// Shared multiplier. Its product is registered every cycle; the sequencer picks
	// the operands for the proportional, integral and derivative terms in turn.
	// ---------------------------------------------------------------------------------
	always_comb begin
		case (state_q)
			ST_MUL_I: begin
				mul_a = i_gain_q;
				mul_b = 33'(esum_q);
			end
			ST_MUL_D: begin
				mul_a = d_gain_q;
				mul_b = dterm_q;
			end
			default: begin
				mul_a = p_gain_q;
				mul_b = 33'(err_q);
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// The proportional magnitude is halved while its whole part exceeds the limit.
	assign halve_more = (mag_q[ppid_pkg::MAG_W-1:8] >
		(ppid_pkg::MAG_W - 8)'(ppid_pkg::P_LIMIT));

	// Divide the Q.8 sum by 256 rounding toward zero, then saturate to 32 bits.
	assign acc_adj   = acc_q + $signed(ppid_pkg::ACC_W'(acc_q[ppid_pkg::ACC_W-1] ? 8'hFF : 8'h00));
	assign acc_whole = acc_adj >>> 8;

	always_comb begin
		if ((acc_whole[ppid_pkg::ACC_W-1:31] == '0) || (acc_whole[ppid_pkg::ACC_W-1:31] == '1)) begin
			cmd_sat = acc_whole[31:0];
		end else if (acc_whole[ppid_pkg::ACC_W-1]) begin
			cmd_sat = 32'sh8000_0000;
		end else begin
			cmd_sat = 32'sh7FFF_FFFF;
		end
	end

	// ---------------------------------------------------------------------------------
	// Sequencer, controller state and output register.
	// ---------------------------------------------------------------------------------
	// The finished beat moves to the output register once that register is free or
	// is being drained in the same cycle.
	assign push = (state_q == ST_PUSH) && (!result_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			esum_q         <= '0;
			last_err_q     <= '0;
			track_pos_q    <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (push) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (is_hold) begin
							state_q <= ST_ERR;
						end else if (is_track) begin
							state_q <= ST_TARGET;
						end else if (item.operation == ppid_pkg::OP_READ) begin
							state_q <= ST_READ;
						end else begin
							// Idle ticks (including the unused mode) clear the controller.
							if (is_tick) begin
								esum_q      <= '0;
								last_err_q  <= '0;
								track_pos_q <= '0;
							end
							state_q <= ST_PUSH;
						end
					end
				end
				ST_TARGET: state_q <= ST_ERR;
				ST_READ:   state_q <= ST_PUSH;
				ST_ERR:    state_q <= ST_INTEG;
				ST_INTEG: begin
					esum_q     <= sat33(33'(esum_q) + 33'(err_q));
					last_err_q <= err_q;
					if (track_q) begin
						track_pos_q <= trk_wrap ? '0 : ppid_pkg::TRAJ_AW'(trk_next);
					end
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: state_q <= ST_MUL_I;
				ST_MUL_I: state_q <= ST_MUL_D;
				ST_MUL_D: state_q <= ST_ACC_D;
				ST_ACC_D: state_q <= ST_HALVE;
				ST_HALVE: begin
					if (!halve_more) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_PUSH;
				ST_PUSH: begin
					if (push) begin
						result_q <= res_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers carry no reset; the sequencer qualifies every use.
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					track_q  <= is_track;
					enc_q    <= item.encoder_count;
					target_q <= hold_target_q;
					res_q    <= '0;
				end
			end
			ST_TARGET: target_q <= ref_rdata;
			ST_READ:   res_q.read_value <= meas_rdata;
			ST_ERR:    err_q <= sat33(33'(target_q) - 33'(enc_q));
			ST_INTEG: begin
				dterm_q <= 33'(last_err_q) - 33'(err_q);
				if (track_q) begin
					res_q.track_done <= trk_wrap;
				end
			end
			ST_MUL_I: begin
				// The proportional product is in the product register now.
				mag_q   <= prod_q[ppid_pkg::PROD_W-1] ? ppid_pkg::MAG_W'(-prod_q)
					: ppid_pkg::MAG_W'(prod_q);
				psign_q <= prod_q[ppid_pkg::PROD_W-1];
			end
			ST_MUL_D: acc_q <= ppid_pkg::ACC_W'(prod_q);
			ST_ACC_D: acc_q <= acc_q + ppid_pkg::ACC_W'(prod_q);
			ST_HALVE: begin
				if (halve_more) begin
					mag_q <= mag_q >> 1;
				end else if (psign_q) begin
					acc_q <= acc_q - $signed(ppid_pkg::ACC_W'(mag_q));
				end else begin
					acc_q <= acc_q + $signed(ppid_pkg::ACC_W'(mag_q));
				end
			end
			ST_FIN: begin
				res_q.command_positive <= !acc_q[ppid_pkg::ACC_W-1] && (acc_q != '0);
				res_q.current_command  <= cmd_sat;
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ---------------------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !item_ready)
		else $error("sequencer took a beat but stayed ready");

	a_halving_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (mag_q[ppid_pkg::MAG_W-1:8] <=
			(ppid_pkg::MAG_W - 8)'(ppid_pkg::P_LIMIT)))
		else $error("proportional term left above its limit");

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_tick && !is_hold && !is_track) |=>
			(esum_q == '0) && (last_err_q == '0) && (track_pos_q == '0))
		else $error("idle tick did not clear the controller");

	a_sign_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> !(result_q.command_positive && result_q.current_command[31]))
		else $error("positive flag on a negative command");

endmodule

>>> hw/rtl/ppid_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module ppid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
